// File: rtl/core/vna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the vertex normal accumulator.
// No dependencies; imported by every module of the block.
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int IDX_W            = 12;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Work for the back end, as classified by the front end.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_TRI,
        OP_READ,
        OP_READ_ZERO
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        logic [95:0]      pos;    // {z, y, x}, Q16.16 each
        logic [47:0]      nrm;    // {z, y, x}, Q1.14 each
        logic [IDX_W-1:0] ca;
        logic [IDX_W-1:0] cb;
        logic [IDX_W-1:0] cc;
    } item_t;

endpackage
`default_nettype wire

// File: rtl/core/vertex_normal_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the vertex normal accumulator: front end, work queue, back end.
// Depends on vna_pkg, vna_front and vna_back (which holds vna_norm).

// The block keeps VERTEX_COUNT vertices, each a Q16.16 position and a Q1.14
// normal, in two single-port-read memories inside the back end; their
// contents are undefined until written, so no clearing pass follows reset.
// A write item loads one vertex; a read item returns one normal and may
// wait on m_ready. A triangle item reads the three corner positions, forms
// the edges (halving them if they exceed +/-2^30), builds the cross product
// on one 32x32 multiplier, then runs four normalizations (face, then each
// corner sum) through one shared unit and writes corners a, b, c in that
// order. Each normalization runs scaling steps, the sum of squares, the
// bit-serial square root and a restoring divide per component.
// Items are processed one at a time; a two-entry queue lets the input side
// take up to two items ahead of the back end, and items that change nothing
// (unused kind, out-of-range write or triangle) are accepted and dropped.
// Only read items produce a result transfer; an out-of-range read returns a
// zero normal.
module vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_kind,
    input  wire logic [vna_pkg::IDX_W-1:0] s_vertex_index,
    input  wire logic signed [31:0]        s_pos_x,
    input  wire logic signed [31:0]        s_pos_y,
    input  wire logic signed [31:0]        s_pos_z,
    input  wire logic signed [15:0]        s_init_normal_x,
    input  wire logic signed [15:0]        s_init_normal_y,
    input  wire logic signed [15:0]        s_init_normal_z,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_a,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_b,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_c,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [vna_pkg::IDX_W-1:0]      m_read_index,
    output logic signed [15:0]             m_normal_out_x,
    output logic signed [15:0]             m_normal_out_y,
    output logic signed [15:0]             m_normal_out_z
);
    import vna_pkg::*;

    // Queue head between front and back.
    logic  head_valid;
    item_t head;
    logic  pop;

    // Classify and queue input transfers.
    vna_front #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_vertex_index (s_vertex_index),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_init_normal_x(s_init_normal_x),
        .s_init_normal_y(s_init_normal_y),
        .s_init_normal_z(s_init_normal_z),
        .s_corner_a     (s_corner_a),
        .s_corner_b     (s_corner_b),
        .s_corner_c     (s_corner_c),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop)
    );

    // Execute queued work and hold the result register.
    vna_back #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_index  (m_read_index),
        .m_normal_out_x(m_normal_out_x),
        .m_normal_out_y(m_normal_out_y),
        .m_normal_out_z(m_normal_out_z)
    );

endmodule
`default_nettype wire

// File: rtl/core/vna_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts input transfers, classifies them and queues the work.
// Depends on vna_pkg.
module vna_front #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_kind,
    input  wire logic [vna_pkg::IDX_W-1:0] s_vertex_index,
    input  wire logic signed [31:0]      s_pos_x,
    input  wire logic signed [31:0]      s_pos_y,
    input  wire logic signed [31:0]      s_pos_z,
    input  wire logic signed [15:0]      s_init_normal_x,
    input  wire logic signed [15:0]      s_init_normal_y,
    input  wire logic signed [15:0]      s_init_normal_z,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_a,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_b,
    input  wire logic [vna_pkg::IDX_W-1:0] s_corner_c,
    output logic                         head_valid,
    output vna_pkg::item_t               head,
    input  wire logic                    pop
);
    import vna_pkg::*;

    item_t      q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic  vi_ok, tri_ok, keep, push;
    item_t cls;

    assign vi_ok  = {20'd0, s_vertex_index} < VERTEX_COUNT;
    assign tri_ok = ({20'd0, s_corner_a} < VERTEX_COUNT) &&
                    ({20'd0, s_corner_b} < VERTEX_COUNT) &&
                    ({20'd0, s_corner_c} < VERTEX_COUNT);

    always_comb begin
        cls.index = s_vertex_index;
        cls.pos   = {s_pos_z, s_pos_y, s_pos_x};
        cls.nrm   = {s_init_normal_z, s_init_normal_y, s_init_normal_x};
        cls.ca    = s_corner_a;
        cls.cb    = s_corner_b;
        cls.cc    = s_corner_c;
        cls.op    = OP_WRITE;
        keep      = 1'b0;
        unique case (s_kind)
            KIND_WRITE: begin
                cls.op = OP_WRITE;
                keep   = vi_ok;
            end
            KIND_TRI: begin
                cls.op = OP_TRI;
                keep   = tri_ok;
            end
            KIND_READ: begin
                cls.op = vi_ok ? OP_READ : OP_READ_ZERO;
                keep   = 1'b1;
            end
            default: keep = 1'b0;   // unused kind: drop
        endcase
    end

    assign s_ready    = count_reg < 2'(QUEUE_DEPTH);
    assign push       = s_valid && s_ready && keep;
    assign head_valid = count_reg != 2'd0;
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/vna_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared normalization unit: scale, sum of squares, bit-serial square root,
// restoring divide per component. Depends on vna_pkg.
module vna_norm (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [63:0] vec_x,
    input  wire logic signed [63:0] vec_y,
    input  wire logic signed [63:0] vec_z,
    output logic                    done,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic signed [15:0]      out_z
);
    import vna_pkg::*;

    typedef enum logic [2:0] {
        N_IDLE, N_SCALE, N_SQ, N_ROOT, N_DLOAD, N_DIV, N_STORE, N_DONE
    } nstate_t;

    localparam logic [63:0] HI_LIM = 64'd1 << 30;
    localparam logic [63:0] LO_LIM = 64'd1 << 29;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    nstate_t            state_reg;
    logic signed [63:0] v_reg [3];
    logic [63:0]        m_reg;
    logic [2:0]         cnt_reg;
    logic [4:0]         step_reg;
    logic [1:0]         comp_reg;
    logic [61:0]        p_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        n_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        low_reg;
    logic [15:0]        q_reg;
    logic               neg_reg;
    logic signed [15:0] out_reg [3];

    logic [63:0] m0, m1, m2, m_in;
    logic [1:0]  sq_sel;
    logic [63:0] sq_mag;
    logic [61:0] sq_prod;
    logic [63:0] trial;
    logic [31:0] len;
    logic [63:0] d_mag;
    logic [45:0] numer;
    logic [32:0] rem2;
    logic        ge;

    always_comb begin
        m0   = mag64(vec_x);
        m1   = mag64(vec_y);
        m2   = mag64(vec_z);
        m_in = m0;
        if (m1 > m_in) m_in = m1;
        if (m2 > m_in) m_in = m2;
    end

    assign sq_sel  = (cnt_reg == 3'd3) ? 2'd0 : cnt_reg[1:0];
    assign sq_mag  = mag64(v_reg[sq_sel]);
    assign sq_prod = sq_mag[30:0] * sq_mag[30:0];
    assign trial   = r_reg + bit_reg;
    assign len     = r_reg[31:0];
    assign d_mag   = mag64(v_reg[comp_reg]);
    assign numer   = (46'(d_mag[30:0]) << 14) + 46'(len >> 1);
    assign rem2    = {rem_reg, low_reg[15]};
    assign ge      = rem2 >= {1'b0, len};

    assign done  = state_reg == N_DONE;
    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            unique case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        v_reg[0] <= vec_x;
                        v_reg[1] <= vec_y;
                        v_reg[2] <= vec_z;
                        m_reg    <= m_in;
                        if (m_in == 64'd0) begin
                            out_reg[0] <= '0;
                            out_reg[1] <= '0;
                            out_reg[2] <= '0;
                            state_reg  <= N_DONE;
                        end else begin
                            state_reg <= N_SCALE;
                        end
                    end
                end
                // Bring the largest magnitude into [2^29, 2^30], 8 or 1 bits a step.
                N_SCALE: begin
                    if (m_reg > HI_LIM) begin
                        if ((m_reg >> 8) > HI_LIM) begin
                            m_reg <= m_reg >> 8;
                            for (int i = 0; i < 3; i++) v_reg[i] <= v_reg[i] >>> 8;
                        end else begin
                            m_reg <= m_reg >> 1;
                            for (int i = 0; i < 3; i++) v_reg[i] <= v_reg[i] >>> 1;
                        end
                    end else if (m_reg < LO_LIM) begin
                        if ((m_reg << 8) < LO_LIM) begin
                            m_reg <= m_reg << 8;
                            for (int i = 0; i < 3; i++) v_reg[i] <= v_reg[i] <<< 8;
                        end else begin
                            m_reg <= m_reg << 1;
                            for (int i = 0; i < 3; i++) v_reg[i] <= v_reg[i] <<< 1;
                        end
                    end else begin
                        cnt_reg   <= 3'd0;
                        sum_reg   <= 64'd0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ: begin
                    p_reg   <= sq_prod;
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0) begin
                        sum_reg <= sum_reg + 64'(p_reg);
                    end
                    if (cnt_reg == 3'd3) begin
                        n_reg     <= sum_reg + 64'(p_reg);
                        r_reg     <= 64'd0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (n_reg >= trial) begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        comp_reg  <= 2'd0;
                        state_reg <= N_DLOAD;
                    end
                end
                N_DLOAD: begin
                    rem_reg   <= 32'(numer[45:16]);
                    low_reg   <= numer[15:0];
                    neg_reg   <= v_reg[comp_reg][63];
                    q_reg     <= 16'd0;
                    step_reg  <= 5'd0;
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    rem_reg  <= ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
                    low_reg  <= {low_reg[14:0], 1'b0};
                    q_reg    <= {q_reg[14:0], ge};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd15) begin
                        state_reg <= N_STORE;
                    end
                end
                N_STORE: begin
                    out_reg[comp_reg] <= neg_reg ? -q_reg : q_reg;
                    if (comp_reg == 2'd2) begin
                        state_reg <= N_DONE;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= N_DLOAD;
                    end
                end
                N_DONE: state_reg <= N_IDLE;
                default: state_reg <= N_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/vna_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: vertex stores, triangle sequencer, cross product and result register.
// Depends on vna_pkg and vna_norm.
module vna_back #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      head_valid,
    input  wire vna_pkg::item_t            head,
    output logic                           pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [vna_pkg::IDX_W-1:0]      m_read_index,
    output logic signed [15:0]             m_normal_out_x,
    output logic signed [15:0]             m_normal_out_y,
    output logic signed [15:0]             m_normal_out_z
);
    import vna_pkg::*;

    localparam int AW = $clog2(VERTEX_COUNT);

    typedef enum logic [3:0] {
        B_IDLE, B_WR, B_RD, B_OUT,
        T_RA, T_RB, T_RC, T_EDGE, T_SCALE, T_CROSS,
        T_FACE, T_FWAIT, T_NRD, T_NSUM, T_NWAIT, T_WR
    } bstate_t;

    localparam logic signed [32:0] EMAX = 33'sd1073741824;
    localparam logic signed [32:0] EMIN = -33'sd1073741824;

    logic [95:0] pos_mem [VERTEX_COUNT];
    logic [47:0] nrm_mem [VERTEX_COUNT];
    logic [95:0] pos_rdata_reg;
    logic [47:0] nrm_rdata_reg;

    bstate_t            state_reg;
    item_t              cur_reg;
    logic [95:0]        pa_reg;
    logic [95:0]        pb_reg;
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic [1:0]         scnt_reg;
    logic [2:0]         cnt_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] cr_reg [3];
    logic signed [15:0] face_reg [3];
    logic [47:0]        fresh_reg [3];
    logic [1:0]         k_reg;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_index_reg;
    logic [47:0]        m_nrm_reg;

    logic [IDX_W-1:0]   idx_k;
    logic [AW-1:0]      pos_raddr, nrm_raddr, nrm_waddr;
    logic               pos_we, nrm_we;
    logic [47:0]        nrm_wdata;
    logic               big;
    logic signed [31:0] mul_a, mul_b;
    logic [2:0]         acc_j;
    logic               out_load;
    logic               norm_start, norm_done;
    logic signed [63:0] norm_vx, norm_vy, norm_vz;
    logic signed [15:0] norm_ox, norm_oy, norm_oz;
    logic signed [32:0] pc_x, pc_y, pc_z;

    always_comb begin
        case (k_reg)
            2'd0:    idx_k = cur_reg.ca;
            2'd1:    idx_k = cur_reg.cb;
            default: idx_k = cur_reg.cc;
        endcase
    end

    always_comb begin
        case (state_reg)
            T_RA:    pos_raddr = AW'(cur_reg.ca);
            T_RB:    pos_raddr = AW'(cur_reg.cb);
            T_RC:    pos_raddr = AW'(cur_reg.cc);
            default: pos_raddr = AW'(cur_reg.index);
        endcase
    end

    assign nrm_raddr = (state_reg == T_NRD) ? AW'(idx_k) : AW'(cur_reg.index);
    assign pos_we    = state_reg == B_WR;
    assign nrm_we    = (state_reg == B_WR) || (state_reg == T_WR);
    assign nrm_waddr = (state_reg == T_WR) ? AW'(idx_k) : AW'(cur_reg.index);
    assign nrm_wdata = (state_reg == T_WR) ? fresh_reg[k_reg] : cur_reg.nrm;

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[AW'(cur_reg.index)] <= cur_reg.pos;
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nrm_we) begin
            nrm_mem[nrm_waddr] <= nrm_wdata;
        end
        nrm_rdata_reg <= nrm_mem[nrm_raddr];
    end

    // Third corner arrives straight from the store read.
    assign pc_x = {pos_rdata_reg[31], pos_rdata_reg[31:0]};
    assign pc_y = {pos_rdata_reg[63], pos_rdata_reg[63:32]};
    assign pc_z = {pos_rdata_reg[95], pos_rdata_reg[95:64]};

    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (e1_reg[i] > EMAX || e1_reg[i] < EMIN ||
                e2_reg[i] > EMAX || e2_reg[i] < EMIN) begin
                big = 1'b1;
            end
        end
    end

    // Cross product terms, one product a cycle: x, y, z each as p0 - p1.
    always_comb begin
        case (cnt_reg)
            3'd0:    begin mul_a = e1_reg[1][31:0]; mul_b = e2_reg[2][31:0]; end
            3'd1:    begin mul_a = e1_reg[2][31:0]; mul_b = e2_reg[1][31:0]; end
            3'd2:    begin mul_a = e1_reg[2][31:0]; mul_b = e2_reg[0][31:0]; end
            3'd3:    begin mul_a = e1_reg[0][31:0]; mul_b = e2_reg[2][31:0]; end
            3'd4:    begin mul_a = e1_reg[0][31:0]; mul_b = e2_reg[1][31:0]; end
            default: begin mul_a = e1_reg[1][31:0]; mul_b = e2_reg[0][31:0]; end
        endcase
    end

    assign acc_j = cnt_reg - 3'd1;

    always_comb begin
        norm_start = (state_reg == T_FACE) || (state_reg == T_NSUM);
        if (state_reg == T_FACE) begin
            norm_vx = cr_reg[0];
            norm_vy = cr_reg[1];
            norm_vz = cr_reg[2];
        end else begin
            norm_vx = 64'(signed'(nrm_rdata_reg[15:0]))  + 64'(face_reg[0]);
            norm_vy = 64'(signed'(nrm_rdata_reg[31:16])) + 64'(face_reg[1]);
            norm_vz = 64'(signed'(nrm_rdata_reg[47:32])) + 64'(face_reg[2]);
        end
    end

    vna_norm u_norm (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (norm_start),
        .vec_x  (norm_vx),
        .vec_y  (norm_vy),
        .vec_z  (norm_vz),
        .done   (norm_done),
        .out_x  (norm_ox),
        .out_y  (norm_oy),
        .out_z  (norm_oz)
    );

    assign pop      = (state_reg == B_IDLE) && head_valid;
    assign out_load = (state_reg == B_OUT) && (!m_valid_reg || m_ready);

    assign m_valid        = m_valid_reg;
    assign m_read_index   = m_index_reg;
    assign m_normal_out_x = m_nrm_reg[15:0];
    assign m_normal_out_y = m_nrm_reg[31:16];
    assign m_normal_out_z = m_nrm_reg[47:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_index_reg <= cur_reg.index;
                m_nrm_reg   <= (cur_reg.op == OP_READ_ZERO) ? 48'd0 : nrm_rdata_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                B_IDLE: begin
                    if (head_valid) begin
                        cur_reg <= head;
                        k_reg   <= 2'd0;
                        unique case (head.op)
                            OP_WRITE:     state_reg <= B_WR;
                            OP_TRI:       state_reg <= T_RA;
                            OP_READ:      state_reg <= B_RD;
                            OP_READ_ZERO: state_reg <= B_OUT;
                            default:      state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_WR:  state_reg <= B_IDLE;
                B_RD:  state_reg <= B_OUT;
                B_OUT: begin
                    if (out_load) state_reg <= B_IDLE;
                end
                T_RA: state_reg <= T_RB;
                T_RB: begin
                    pa_reg    <= pos_rdata_reg;
                    state_reg <= T_RC;
                end
                T_RC: begin
                    pb_reg    <= pos_rdata_reg;
                    state_reg <= T_EDGE;
                end
                T_EDGE: begin
                    e1_reg[0] <= {pb_reg[31], pb_reg[31:0]}  - {pa_reg[31], pa_reg[31:0]};
                    e1_reg[1] <= {pb_reg[63], pb_reg[63:32]} - {pa_reg[63], pa_reg[63:32]};
                    e1_reg[2] <= {pb_reg[95], pb_reg[95:64]} - {pa_reg[95], pa_reg[95:64]};
                    e2_reg[0] <= pc_x - {pa_reg[31], pa_reg[31:0]};
                    e2_reg[1] <= pc_y - {pa_reg[63], pa_reg[63:32]};
                    e2_reg[2] <= pc_z - {pa_reg[95], pa_reg[95:64]};
                    scnt_reg  <= 2'd0;
                    state_reg <= T_SCALE;
                end
                // Halve both edges, at most twice, until all fit in +/-2^30.
                T_SCALE: begin
                    if (big && scnt_reg != 2'd2) begin
                        for (int i = 0; i < 3; i++) begin
                            e1_reg[i] <= e1_reg[i] >>> 1;
                            e2_reg[i] <= e2_reg[i] >>> 1;
                        end
                        scnt_reg <= scnt_reg + 2'd1;
                    end else begin
                        cnt_reg   <= 3'd0;
                        state_reg <= T_CROSS;
                    end
                end
                T_CROSS: begin
                    prod_reg <= mul_a * mul_b;
                    cnt_reg  <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0) begin
                        if (!acc_j[0]) begin
                            cr_reg[acc_j[2:1]] <= prod_reg;
                        end else begin
                            cr_reg[acc_j[2:1]] <= cr_reg[acc_j[2:1]] - prod_reg;
                        end
                    end
                    if (cnt_reg == 3'd6) state_reg <= T_FACE;
                end
                T_FACE: state_reg <= T_FWAIT;
                T_FWAIT: begin
                    if (norm_done) begin
                        face_reg[0] <= norm_ox;
                        face_reg[1] <= norm_oy;
                        face_reg[2] <= norm_oz;
                        k_reg       <= 2'd0;
                        state_reg   <= T_NRD;
                    end
                end
                T_NRD:  state_reg <= T_NSUM;
                T_NSUM: state_reg <= T_NWAIT;
                T_NWAIT: begin
                    if (norm_done) begin
                        fresh_reg[k_reg] <= {norm_oz, norm_oy, norm_ox};
                        if (k_reg == 2'd2) begin
                            k_reg     <= 2'd0;
                            state_reg <= T_WR;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= T_NRD;
                        end
                    end
                end
                // Write corners a, b, c in order so a repeated index keeps the last.
                T_WR: begin
                    if (k_reg == 2'd2) begin
                        state_reg <= B_IDLE;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for vertex_normal_accumulator: directed corner cases,
// then random vertex writes, triangle updates and normal reads.
// Depends on vna_pkg and the RTL of the block; the prediction is built in.
module tb;
    import vna_pkg::*;

    // Unused kind: the block accepts it and does nothing.
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int         N_RANDOM  = 1430;
    localparam int         TAIL_LEN  = 120;
    localparam int         DRAIN_CYC = 1000;

    typedef struct {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   vidx;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic [IDX_W-1:0]   ca, cb, cc;
    } vtx_item_t;

    typedef struct {
        logic [IDX_W-1:0]   vidx;
        logic signed [15:0] nx, ny, nz;
    } normal_rd_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Every input starts at a known value.
    logic                      s_valid         = 1'b0;
    logic [1:0]                s_kind          = '0;
    logic [IDX_W-1:0]          s_vertex_index  = '0;
    logic signed [31:0]        s_pos_x         = '0;
    logic signed [31:0]        s_pos_y         = '0;
    logic signed [31:0]        s_pos_z         = '0;
    logic signed [15:0]        s_init_normal_x = '0;
    logic signed [15:0]        s_init_normal_y = '0;
    logic signed [15:0]        s_init_normal_z = '0;
    logic [IDX_W-1:0]          s_corner_a      = '0;
    logic [IDX_W-1:0]          s_corner_b      = '0;
    logic [IDX_W-1:0]          s_corner_c      = '0;
    logic                      m_ready         = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [IDX_W-1:0]          m_read_index;
    logic signed [15:0]        m_normal_out_x;
    logic signed [15:0]        m_normal_out_y;
    logic signed [15:0]        m_normal_out_z;

    vertex_normal_accumulator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_vertex_index  (s_vertex_index),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_init_normal_x (s_init_normal_x),
        .s_init_normal_y (s_init_normal_y),
        .s_init_normal_z (s_init_normal_z),
        .s_corner_a      (s_corner_a),
        .s_corner_b      (s_corner_b),
        .s_corner_c      (s_corner_c),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_index    (m_read_index),
        .m_normal_out_x  (m_normal_out_x),
        .m_normal_out_y  (m_normal_out_y),
        .m_normal_out_z  (m_normal_out_z)
    );

    // 20 ns clock.
    always #10 aclk = ~aclk;

    vtx_item_t  pending_items[$];   // stimulus not yet driven
    normal_rd_t expected_reads[$];  // read results still owed by the block
    int         err_count = 0;

    // Shadow copy of the vertex store, updated at each accepted transfer.
    logic signed [31:0] pos_mem [0:4095][0:2];
    logic signed [15:0] nrm_mem [0:4095][0:2];

    // Generation-side bookkeeping: which vertices hold data, so that no read
    // or triangle ever touches an entry that was never written.
    bit         gen_written [0:4095];
    int         written_list[$];
    int         hot_set[$];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned absval(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned sqrt_floor(input longint unsigned n);
        longint unsigned r   = 0;
        longint unsigned bit_w = 64'd1 << 62;
        while (bit_w > n)
            bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= r + bit_w) begin
                n = n - (r + bit_w);
                r = (r >> 1) + bit_w;
            end else begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    // Unit vector in Q1.14, packed {z, y, x}. Zero length gives zero.
    function automatic logic [47:0] unit_vec(input longint x, input longint y,
                                             input longint z);
        longint          v [3];
        longint unsigned m, sum, len, q;
        int              s;
        logic [47:0]     r;
        v[0] = x; v[1] = y; v[2] = z;
        m = 0;
        for (int i = 0; i < 3; i++)
            if (absval(v[i]) > m) m = absval(v[i]);
        if (m == 0)
            return '0;
        s = 0;
        // Bring the largest magnitude into [2^29, 2^30].
        if (m > (64'd1 << 30)) begin
            while ((m >> s) > (64'd1 << 30)) s++;
            for (int i = 0; i < 3; i++) v[i] = v[i] >>> s;
        end else begin
            while ((m << s) < (64'd1 << 29)) s++;
            for (int i = 0; i < 3; i++) v[i] = v[i] <<< s;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += absval(v[i]) * absval(v[i]);
        len = sqrt_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = (absval(v[i]) * 64'd16384 + (len >> 1)) / len;
            r[16*i +: 16] = (v[i] < 0) ? 16'(-longint'(q)) : 16'(q);
        end
        return r;
    endfunction

    task automatic apply_triangle(input int a, input int b, input int c);
        int                 idx [3];
        longint             e1 [3], e2 [3], cr [3];
        logic [47:0]        face;
        logic [47:0]        fresh [3];
        logic signed [15:0] fc;
        bit                 big;
        idx[0] = a; idx[1] = b; idx[2] = c;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
            e2[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
        end
        // Halve the edges, at most twice, until every component fits 2^30.
        for (int s = 0; s < 2; s++) begin
            big = 1'b0;
            for (int i = 0; i < 3; i++)
                if (absval(e1[i]) > (64'd1 << 30) || absval(e2[i]) > (64'd1 << 30))
                    big = 1'b1;
            if (big)
                for (int i = 0; i < 3; i++) begin
                    e1[i] = e1[i] >>> 1;
                    e2[i] = e2[i] >>> 1;
                end
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        face = unit_vec(cr[0], cr[1], cr[2]);
        // All three sums come from the normals before the update.
        for (int k = 0; k < 3; k++) begin
            longint sm [3];
            for (int i = 0; i < 3; i++) begin
                fc    = face[16*i +: 16];
                sm[i] = longint'(nrm_mem[idx[k]][i]) + longint'(fc);
            end
            fresh[k] = unit_vec(sm[0], sm[1], sm[2]);
        end
        // Write a, b, c in order so the last repeat of an index wins.
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                nrm_mem[idx[k]][i] = fresh[k][16*i +: 16];
    endtask

    task automatic predict_item(input vtx_item_t it);
        normal_rd_t rd;
        case (it.kind)
            KIND_WRITE: begin
                pos_mem[it.vidx][0] = it.px;
                pos_mem[it.vidx][1] = it.py;
                pos_mem[it.vidx][2] = it.pz;
                nrm_mem[it.vidx][0] = it.nx;
                nrm_mem[it.vidx][1] = it.ny;
                nrm_mem[it.vidx][2] = it.nz;
            end
            KIND_TRI: apply_triangle(int'(it.ca), int'(it.cb), int'(it.cc));
            KIND_READ: begin
                rd.vidx = it.vidx;
                rd.nx   = nrm_mem[it.vidx][0];
                rd.ny   = nrm_mem[it.vidx][1];
                rd.nz   = nrm_mem[it.vidx][2];
                expected_reads.insert(expected_reads.size(), rd);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        err_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders: unused fields carry random bits.
    // ------------------------------------------------------------------
    function automatic vtx_item_t noise_item(input logic [1:0] kind);
        vtx_item_t it;
        it.kind = kind;
        it.vidx = IDX_W'($urandom);
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
        it.ca = IDX_W'($urandom); it.cb = IDX_W'($urandom); it.cc = IDX_W'($urandom);
        return it;
    endfunction

    task automatic add_write(input int idx, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz,
                             input logic signed [15:0] nx, input logic signed [15:0] ny,
                             input logic signed [15:0] nz);
        vtx_item_t it;
        it = noise_item(KIND_WRITE);
        it.vidx = IDX_W'(idx);
        it.px = px; it.py = py; it.pz = pz;
        it.nx = nx; it.ny = ny; it.nz = nz;
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            written_list.insert(written_list.size(), idx);
        end
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_tri(input int a, input int b, input int c);
        vtx_item_t it;
        it = noise_item(KIND_TRI);
        it.ca = IDX_W'(a); it.cb = IDX_W'(b); it.cc = IDX_W'(c);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_read(input int idx);
        vtx_item_t it;
        it = noise_item(KIND_READ);
        it.vidx = IDX_W'(idx);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            3:       return 32'sh0001_0000;  // shared value: flat triangles
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_nrm();
        case ($urandom_range(0, 7))
            0:       return 16'sd0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:    return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
        endcase
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int r;
        // Directed: extreme indices and values, huge and flat triangles,
        // repeated corners, zero normals, the unused kind.
        add_write(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  16'sh8000, 16'sh8000, 16'sh8000);
        add_write(4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_write(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  16'sd0, 16'sd0, 16'sd0);
        add_write(2, 32'sh0001_0000, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0);
        add_write(3, 32'sd0, 32'sh0001_0000, 32'sd0, 16'sd16384, 16'sd0, 16'sd0);
        add_write(4, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0);
        add_read(0);
        add_read(4095);
        add_tri(0, 4095, 1);      // edges far beyond 2^30
        add_tri(4, 2, 3);         // unit triangle in the xy plane
        add_tri(4, 4, 4);         // flat: zero face normal on zero normal
        add_tri(2, 3, 2);         // repeated corner
        add_read(0);
        add_read(4095);
        add_read(1);
        add_read(2);
        add_read(3);
        add_read(4);
        pending_items.insert(pending_items.size(), noise_item(KIND_NONE));
        add_read(4);

        // Working set small enough that corners repeat and sums build up.
        repeat (40) hot_set.insert(hot_set.size(), int'($urandom_range(0, 4095)));
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 28) begin
                add_write($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                                    : hot_set[$urandom_range(0, 39)],
                          rand_pos(), rand_pos(), rand_pos(),
                          rand_nrm(), rand_nrm(), rand_nrm());
            end else if (r < 60) begin
                add_tri(pick_written(), pick_written(), pick_written());
            end else if (r < 96) begin
                add_read(pick_written());
            end else begin
                pending_items.insert(pending_items.size(), noise_item(KIND_NONE));
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_reads.size() == 0);
        // A trailing triangle may still be running; let it finish.
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_count == 0 && expected_reads.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #(80_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: predict on each transfer, then present the next item or
    // hold off for a random burst. Idling stops for the last items.
    // ------------------------------------------------------------------
    int s_gap = 0;

    always @(posedge aclk) begin
        vtx_item_t it;
        logic      nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_item('{s_kind, s_vertex_index, s_pos_x, s_pos_y, s_pos_z,
                               s_init_normal_x, s_init_normal_y, s_init_normal_z,
                               s_corner_a, s_corner_b, s_corner_c});
            // Hold the current item until it transfers.
            if (!s_valid || s_ready) begin
                nxt_valid = 1'b0;
                if (s_gap > 0) begin
                    s_gap--;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_kind          <= it.kind;
                    s_vertex_index  <= it.vidx;
                    s_pos_x         <= it.px;
                    s_pos_y         <= it.py;
                    s_pos_z         <= it.pz;
                    s_init_normal_x <= it.nx;
                    s_init_normal_y <= it.ny;
                    s_init_normal_z <= it.nz;
                    s_corner_a      <= it.ca;
                    s_corner_b      <= it.cb;
                    s_corner_c      <= it.cc;
                    nxt_valid = 1'b1;
                    if (pending_items.size() > TAIL_LEN && $urandom_range(0, 5) == 0)
                        s_gap = $urandom_range(1, 8);
                end
                s_valid <= nxt_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expected read,
    // and stall m_ready in random bursts until the tail of the run.
    // ------------------------------------------------------------------
    int m_stall = 0;

    always @(posedge aclk) begin
        normal_rd_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("result transfers owed", 1, 0);
                end else begin
                    want = expected_reads.pop_front();
                    if (m_read_index !== want.vidx)
                        report_mismatch("read_index", m_read_index, want.vidx);
                    if (m_normal_out_x !== want.nx)
                        report_mismatch("normal_out_x", m_normal_out_x, want.nx);
                    if (m_normal_out_y !== want.ny)
                        report_mismatch("normal_out_y", m_normal_out_y, want.ny);
                    if (m_normal_out_z !== want.nz)
                        report_mismatch("normal_out_z", m_normal_out_z, want.nz);
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (pending_items.size() > TAIL_LEN && $urandom_range(0, 4) == 0)
                    m_stall = $urandom_range(1, 8);
            end
        end
    end

endmodule

// File: filelist.f
rtl/core/vna_pkg.sv
rtl/core/vna_front.sv
rtl/core/vna_norm.sv
rtl/core/vna_back.sv
rtl/core/vertex_normal_accumulator.sv
sim/tb.sv
